### rtl/core/sbp_pkg.sv
// Shared constants and types for the skeleton bone palette core.
package sbp_pkg;

  localparam int MAX_BONES_DEF = 256;
  localparam int FRAC_BITS_DEF = 16;

  localparam int WORD_W     = 32;
  localparam int BONE_IDX_W = 8;
  localparam int PARENT_W   = 9;
  localparam int COL_W      = 2;

  typedef logic signed [WORD_W-1:0]     word_t;
  typedef logic        [BONE_IDX_W-1:0] bone_idx_t;
  typedef logic signed [PARENT_W-1:0]   parent_idx_t;
  typedef logic        [COL_W-1:0]      col_idx_t;

endpackage

### rtl/core/sbp_in_if.sv
// Input channel: one bone column item with its handshake.
interface sbp_in_if;
  import sbp_pkg::*;

  logic        valid;
  logic        ready;
  bone_idx_t   bone_index;
  parent_idx_t parent_index;
  col_idx_t    column;
  word_t       local_e0;
  word_t       local_e1;
  word_t       local_e2;
  word_t       local_e3;
  word_t       offset_e0;
  word_t       offset_e1;
  word_t       offset_e2;
  word_t       offset_e3;

  modport source (
    output valid, bone_index, parent_index, column,
           local_e0, local_e1, local_e2, local_e3,
           offset_e0, offset_e1, offset_e2, offset_e3,
    input  ready
  );

  modport sink (
    input  valid, bone_index, parent_index, column,
           local_e0, local_e1, local_e2, local_e3,
           offset_e0, offset_e1, offset_e2, offset_e3,
    output ready
  );

endinterface

### rtl/core/sbp_out_if.sv
// Output channel: one skinning matrix column item with its handshake.
interface sbp_out_if;
  import sbp_pkg::*;

  logic      valid;
  logic      ready;
  bone_idx_t out_bone;
  col_idx_t  out_column;
  word_t     skin_e0;
  word_t     skin_e1;
  word_t     skin_e2;
  word_t     skin_e3;
  logic      last_column;
  logic      overflow;

  modport source (
    output valid, out_bone, out_column, skin_e0, skin_e1, skin_e2, skin_e3,
           last_column, overflow,
    input  ready
  );

  modport sink (
    input  valid, out_bone, out_column, skin_e0, skin_e1, skin_e2, skin_e3,
           last_column, overflow,
    output ready
  );

endinterface

### rtl/core/skeleton_bone_palette_core.sv
// Skeleton bone palette core: forward kinematics and skinning matrices in fixed point.
// Steps: a root column is accepted, then makes four store writes; a child column
//   is accepted, makes 16 MAC issues, drains the pipe, then makes four store writes.
// Column 3 adds 64 MAC issues and a drain, then four result items, one per accepted cycle.
// Throughput: one item at a time, set by the shared MAC pipe and the single store port.
// Reset: a clearing pass over all MAX_BONES*16 store words loads identity; no item is taken until then.
module skeleton_bone_palette_core #(
  parameter int MAX_BONES = sbp_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = sbp_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  sbp_in_if.sink   bones,
  sbp_out_if.source skins
);
  import sbp_pkg::*;

  // Global store geometry: element (bone, col, row) sits at {bone, col, row}.
  localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int DEPTH  = MAX_BONES * 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CMP_W  = 11;

  localparam int COL_STEPS  = 16;
  localparam int SKIN_STEPS = 64;

  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] P_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] P_MIN   = -64'sd2147483648;
  localparam logic signed [33:0] S_MAX   = 34'sd2147483647;
  localparam logic signed [33:0] S_MIN   = -34'sd2147483648;
  localparam logic        [31:0] ONE     = 32'd1 << FRAC_BITS;

  // Sequencer states
  localparam logic [2:0] ST_CLEAR      = 3'd0;
  localparam logic [2:0] ST_IDLE       = 3'd1;
  localparam logic [2:0] ST_COL        = 3'd2;
  localparam logic [2:0] ST_COL_DRAIN  = 3'd3;
  localparam logic [2:0] ST_WRITE      = 3'd4;
  localparam logic [2:0] ST_SKIN       = 3'd5;
  localparam logic [2:0] ST_SKIN_DRAIN = 3'd6;
  localparam logic [2:0] ST_EMIT       = 3'd7;

  // Control state
  logic [2:0]    state;
  logic [5:0]    step;
  logic [AW-1:0] clr_addr;
  logic          ovf;
  logic          a_v, b_v, c_v;

  // Item payload held for the duration of the work
  bone_idx_t     bone;
  col_idx_t      col;
  logic [BONE_W-1:0] parent;
  word_t         loc  [4];
  word_t         offs [4][4];   // [column][row]
  word_t         res  [4][4];   // [row of result][lane]; row 0 doubles as new column

  // MAC pipeline registers
  word_t         a_b;
  logic          a_first, a_last;
  logic [3:0]    a_dst;
  logic signed [63:0] prod;
  logic          b_first, b_last;
  logic [3:0]    b_dst;
  word_t         c_prod;
  logic          c_first, c_last;
  logic [3:0]    c_dst;
  logic signed [33:0] acc;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  sbp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Input decode
  logic in_acc, in_range, in_root;
  assign bones.ready = (state == ST_IDLE);
  assign in_acc      = bones.valid && bones.ready;
  assign in_range    = CMP_W'(bones.bone_index) < CMP_W'(MAX_BONES);
  assign in_root     = bones.parent_index[PARENT_W-1] ||
                       (CMP_W'(bones.parent_index[PARENT_W-2:0]) >= CMP_W'(MAX_BONES));

  // Issue stage: pick store word and operand for this MAC step
  logic          issue, skin_ph;
  logic [1:0]    iss_k, iss_r, iss_j;
  word_t         iss_b;
  logic [3:0]    iss_dst;
  logic [BONE_W-1:0] bone_a;

  assign bone_a  = BONE_W'(bone);
  assign skin_ph = (state == ST_SKIN);
  assign issue   = (state == ST_COL) || skin_ph;
  assign iss_k   = step[1:0];
  assign iss_r   = step[3:2];
  assign iss_j   = step[5:4];

  always_comb begin
    ram_raddr = AW'({(skin_ph ? bone_a : parent), iss_k, iss_r});
    iss_b     = skin_ph ? offs[iss_j][iss_k] : loc[iss_k];
    iss_dst   = skin_ph ? {iss_j, iss_r} : {2'b00, iss_r};
  end

  // Store writes: clearing pass or the new global column
  always_comb begin
    ram_we = (state == ST_CLEAR) || (state == ST_WRITE);
    if (state == ST_CLEAR) begin
      ram_waddr = clr_addr;
      ram_wdata = (clr_addr[3:2] == clr_addr[1:0]) ? ONE : 32'd0;
    end else begin
      ram_waddr = AW'({bone_a, col, step[1:0]});
      ram_wdata = res[0][step[1:0]];
    end
  end

  // Round, shift and saturate the product; add and saturate the dot sum
  logic signed [63:0] rnd, shd;
  logic signed [33:0] acc_sum;
  word_t              prod_sat, sum_sat;
  logic               prod_ovf, sum_ovf;

  always_comb begin
    rnd = prod + HALF;
    shd = rnd >>> FRAC_BITS;
    prod_ovf = 1'b1;
    if (shd > P_MAX) begin
      prod_sat = word_t'(P_MAX[31:0]);
    end else if (shd < P_MIN) begin
      prod_sat = word_t'(P_MIN[31:0]);
    end else begin
      prod_sat = word_t'(shd[31:0]);
      prod_ovf = 1'b0;
    end

    acc_sum = (c_first ? 34'sd0 : acc) + 34'(c_prod);
    sum_ovf = 1'b1;
    if (acc_sum > S_MAX) begin
      sum_sat = word_t'(S_MAX[31:0]);
    end else if (acc_sum < S_MIN) begin
      sum_sat = word_t'(S_MIN[31:0]);
    end else begin
      sum_sat = word_t'(acc_sum[31:0]);
      sum_ovf = 1'b0;
    end
  end

  logic pipe_empty, out_acc;
  assign pipe_empty = !a_v && !b_v && !c_v;
  assign out_acc    = skins.valid && skins.ready;

  // Overflow flag: clear at start of bone and after the last result
  logic ovf_next;
  always_comb begin
    ovf_next = ovf;
    if (in_acc && in_range && (bones.column == 2'd0)) begin
      ovf_next = 1'b0;
    end else if ((state == ST_EMIT) && out_acc && (step[1:0] == 2'd3)) begin
      ovf_next = 1'b0;
    end else begin
      if (b_v && prod_ovf)           ovf_next = 1'b1;
      if (c_v && c_last && sum_ovf)  ovf_next = 1'b1;
    end
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      step     <= '0;
      clr_addr <= '0;
      ovf      <= 1'b0;
      a_v      <= 1'b0;
      b_v      <= 1'b0;
      c_v      <= 1'b0;
    end else begin
      ovf <= ovf_next;
      a_v <= issue;
      b_v <= a_v;
      c_v <= b_v && !b_last ? 1'b1 : b_v;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && in_range) begin
            step  <= '0;
            state <= in_root ? ST_WRITE : ST_COL;
          end
        end
        ST_COL: begin
          if (step == 6'(COL_STEPS - 1)) begin
            step  <= '0;
            state <= ST_COL_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_COL_DRAIN: begin
          if (pipe_empty) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (step[1:0] == 2'd3) begin
            step  <= '0;
            state <= (col == 2'd3) ? ST_SKIN : ST_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SKIN: begin
          if (step == 6'(SKIN_STEPS - 1)) begin
            step  <= '0;
            state <= ST_SKIN_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SKIN_DRAIN: begin
          if (pipe_empty) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (step[1:0] == 2'd3) begin
              step  <= '0;
              state <= ST_IDLE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    // Latch the item; write its offset column; a root column goes straight to row 0
    if (in_acc && in_range) begin
      bone   <= bones.bone_index;
      col    <= bones.column;
      parent <= BONE_W'(bones.parent_index[PARENT_W-2:0]);
      loc[0] <= bones.local_e0;
      loc[1] <= bones.local_e1;
      loc[2] <= bones.local_e2;
      loc[3] <= bones.local_e3;
      offs[bones.column][0] <= bones.offset_e0;
      offs[bones.column][1] <= bones.offset_e1;
      offs[bones.column][2] <= bones.offset_e2;
      offs[bones.column][3] <= bones.offset_e3;
      if (in_root) begin
        res[0][0] <= bones.local_e0;
        res[0][1] <= bones.local_e1;
        res[0][2] <= bones.local_e2;
        res[0][3] <= bones.local_e3;
      end
    end

    // Issue tag travels alongside the store read
    a_b     <= iss_b;
    a_first <= (iss_k == 2'd0);
    a_last  <= (iss_k == 2'd3);
    a_dst   <= iss_dst;

    // Multiply the store word by the operand
    prod    <= $signed(ram_rdata) * a_b;
    b_first <= a_first;
    b_last  <= a_last;
    b_dst   <= a_dst;

    // Round and saturate the product
    c_prod  <= prod_sat;
    c_first <= b_first;
    c_last  <= b_last;
    c_dst   <= b_dst;

    // Accumulate four products; drop the saturated sum into its slot
    if (c_v) begin
      acc <= acc_sum;
      if (c_last) begin
        res[c_dst[3:2]][c_dst[1:0]] <= sum_sat;
      end
    end
  end

  // Results: one skinning column per item, straight from the result rows
  assign skins.valid       = (state == ST_EMIT);
  assign skins.out_bone    = bone;
  assign skins.out_column  = step[1:0];
  assign skins.skin_e0     = res[step[1:0]][0];
  assign skins.skin_e1     = res[step[1:0]][1];
  assign skins.skin_e2     = res[step[1:0]][2];
  assign skins.skin_e3     = res[step[1:0]][3];
  assign skins.last_column = (step[1:0] == 2'd3);
  assign skins.overflow    = ovf;

endmodule

### rtl/core/sbp_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module sbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### verif/tb.sv
// Testbench for the skeleton bone palette core: predicts skinning columns and checks each one.
`timescale 1ns / 100ps

module tb;
  import sbp_pkg::*;

  localparam int MAX_BONES    = MAX_BONES_DEF;
  localparam int FRAC_BITS    = FRAC_BITS_DEF;
  // The clearing pass plus the work per item and stalls on both sides come to
  // well under a fifth of this.
  localparam int LIMIT_CYCLES = 800000;
  // Settling time at the end, longer than column 3 of a child bone takes.
  localparam int DRAIN_CYCLES = 200;
  // Receiver hold-off long enough to fill the block and back up the input.
  localparam int HOLD_CYCLES  = 400;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;
  localparam word_t  ONE     = word_t'(1 << FRAC_BITS);
  localparam word_t  W_MAX   = 32'sh7fff_ffff;
  localparam word_t  W_MIN   = 32'sh8000_0000;

  typedef word_t [3:0] col_vec_t;

  // One skinning column as the block should emit it.
  typedef struct packed {
    bone_idx_t bone;
    col_idx_t  col;
    col_vec_t  skin;
    logic      last;
    logic      ovf;
  } skin_col_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sbp_in_if  bones ();
  sbp_out_if skins ();

  skeleton_bone_palette_core #(
    .MAX_BONES(MAX_BONES),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .bones(bones),
    .skins(skins)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Own copy of the block's state: global pose per bone (column-major),
  // the 4x4 offset buffer and the sticky saturation flag of the current bone.
  word_t pose_store [MAX_BONES][16];
  word_t offset_cols [16];
  logic  sat_seen;

  // Skinning columns predicted but not yet seen on the output, oldest first.
  skin_col_t skin_cols_due [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  bit  idle_on     = 1'b1;
  bit  hold_req    = 1'b0;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the pose pipeline
  // ---------------------------------------------------------------------------

  // Clamp to 32 bits; note any clamping against the current bone.
  function automatic word_t sat_word(longint v);
    if (v > SUM_MAX) begin
      sat_seen = 1'b1;
      return W_MAX;
    end
    if (v < SUM_MIN) begin
      sat_seen = 1'b1;
      return W_MIN;
    end
    return word_t'(v);
  endfunction

  // Exact product, add half an LSB, shift with floor rounding, clamp.
  function automatic word_t fx_product(word_t a, word_t b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
    return sat_word(p >>> FRAC_BITS);
  endfunction

  // Row r of the pose of bone m times vector v; the exact sum is clamped once.
  function automatic word_t row_dot(int m, col_vec_t v, int r);
    longint acc;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc += longint'(fx_product(pose_store[m][k*4 + r], v[k]));
    end
    return sat_word(acc);
  endfunction

  // Advance the pose state by one accepted column item and queue the four
  // skinning columns when it closes a bone.
  task automatic track_bone_column(bone_idx_t b, parent_idx_t p, col_idx_t c,
                                   col_vec_t loc, col_vec_t ofs);
    col_vec_t  fresh;
    col_vec_t  ocol;
    col_vec_t  skin [4];
    skin_col_t due;
    // A bone beyond the palette is dropped without touching any state.
    if (int'(b) >= MAX_BONES) begin
      return;
    end
    if (c == 0) begin
      sat_seen = 1'b0;
    end
    for (int r = 0; r < 4; r++) begin
      offset_cols[c*4 + r] = ofs[r];
    end
    // Roots copy the local column straight through; children take the whole
    // column from the parent pose before any of it is written back, which
    // also covers a bone that names itself as parent.
    if (p < 0 || int'(p) >= MAX_BONES) begin
      fresh = loc;
    end else begin
      for (int r = 0; r < 4; r++) begin
        fresh[r] = row_dot(int'(p), loc, r);
      end
    end
    for (int r = 0; r < 4; r++) begin
      pose_store[b][c*4 + r] = fresh[r];
    end
    if (c != 3) begin
      return;
    end
    // All sixteen products first: the flag sent with every column covers them.
    for (int j = 0; j < 4; j++) begin
      for (int r = 0; r < 4; r++) begin
        ocol[r] = offset_cols[j*4 + r];
      end
      for (int r = 0; r < 4; r++) begin
        skin[j][r] = row_dot(int'(b), ocol, r);
      end
    end
    for (int j = 0; j < 4; j++) begin
      due.bone = b;
      due.col  = col_idx_t'(j);
      due.skin = skin[j];
      due.last = (j == 3);
      due.ovf  = sat_seen;
      skin_cols_due = {skin_cols_due, due};
    end
    sat_seen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Most gaps short, a few long.
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 8) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Mostly values within +/-2.0, some corners, some raw 32-bit patterns.
  function automatic word_t rand_word(bit wide);
    int pick;
    pick = $urandom_range(0, 99);
    if (wide || pick < 8) begin
      return word_t'($urandom);
    end
    if (pick < 14) begin
      case ($urandom_range(0, 4))
        0:       return W_MAX;
        1:       return W_MIN;
        2:       return '0;
        3:       return ONE;
        default: return -ONE;
      endcase
    end
    return word_t'(int'($urandom_range(0, 262143)) - 131072);
  endfunction

  function automatic col_vec_t rand_col(bit wide);
    col_vec_t v;
    for (int r = 0; r < 4; r++) begin
      v[r] = rand_word(wide);
    end
    return v;
  endfunction

  function automatic col_vec_t fill_col(word_t w);
    col_vec_t v;
    for (int r = 0; r < 4; r++) begin
      v[r] = w;
    end
    return v;
  endfunction

  function automatic col_vec_t unit_col(int c, word_t w);
    col_vec_t v;
    v    = '0;
    v[c] = w;
    return v;
  endfunction

  // Offer one column item, hold it until the block takes it, then update the
  // prediction. Valid stays high when the next item follows with no gap.
  task automatic send_col(bone_idx_t b, parent_idx_t p, col_idx_t c,
                          col_vec_t loc, col_vec_t ofs);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      bones.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bones.bone_index   <= b;
    bones.parent_index <= p;
    bones.column       <= c;
    bones.local_e0     <= loc[0];
    bones.local_e1     <= loc[1];
    bones.local_e2     <= loc[2];
    bones.local_e3     <= loc[3];
    bones.offset_e0    <= ofs[0];
    bones.offset_e1    <= ofs[1];
    bones.offset_e2    <= ofs[2];
    bones.offset_e3    <= ofs[3];
    bones.valid        <= 1'b1;
    do @(posedge clk); while (bones.ready !== 1'b1);
    track_bone_column(b, p, c, loc, ofs);
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Parent never processed: the pose store still holds identity from reset.
  // This pass also fills every column of the offset buffer once.
  task automatic test_unvisited_parent();
    for (int c = 0; c < 4; c++) begin
      send_col(8'd5, 9'sd3, col_idx_t'(c), rand_col(1'b0), rand_col(1'b0));
    end
  endtask

  // Root at bone 0 copies extreme columns unchanged; the skinning product of
  // those extremes saturates.
  task automatic test_root_extremes();
    send_col(8'd0, -9'sd1, 2'd0, fill_col(W_MAX), unit_col(0, ONE));
    send_col(8'd0, -9'sd1, 2'd1, fill_col(W_MIN), fill_col(W_MIN));
    send_col(8'd0, -9'sd1, 2'd2, fill_col('0),    fill_col(W_MAX));
    send_col(8'd0, -9'sd1, 2'd3, unit_col(3, ONE), fill_col('0));
  endtask

  // Child of the extreme root: sums and products clamp in the pose itself.
  task automatic test_saturating_child();
    send_col(8'd1, 9'sd0, 2'd0, fill_col(W_MAX), unit_col(0, ONE));
    send_col(8'd1, 9'sd0, 2'd1, fill_col(W_MIN), unit_col(1, ONE));
    send_col(8'd1, 9'sd0, 2'd2, fill_col(-ONE),  unit_col(2, ONE));
    send_col(8'd1, 9'sd0, 2'd3, unit_col(3, ONE), unit_col(3, ONE));
  endtask

  // Highest bone as its own parent: later columns see earlier ones of this pass.
  task automatic test_own_parent();
    send_col(8'd255, 9'sd255, 2'd0, rand_col(1'b0), rand_col(1'b0));
    for (int c = 1; c < 4; c++) begin
      send_col(8'd255, 9'sd255, col_idx_t'(c), unit_col(c, ONE + ONE), rand_col(1'b0));
    end
  endtask

  // Columns out of order, the most negative parent, and a clamp on one bone
  // that is still flagged when another bone closes without a column 0.
  task automatic test_out_of_order();
    send_col(8'd7,  parent_idx_t'(-256), 2'd3, rand_col(1'b0), rand_col(1'b0));
    send_col(8'd7,  parent_idx_t'(-256), 2'd1, rand_col(1'b1), rand_col(1'b0));
    send_col(8'd9,  9'sd1,               2'd2, fill_col(W_MAX), rand_col(1'b0));
    send_col(8'd10, -9'sd1,              2'd3, unit_col(3, ONE), unit_col(3, ONE));
    send_col(8'd10, -9'sd1,              2'd0, unit_col(0, ONE), unit_col(0, ONE));
  endtask

  // Well-formed passes: bones in order, columns 0 to 3, parents mostly earlier
  // bones of the same pass. Every fourth pass runs with no idling at all.
  task automatic test_random_skeletons(int items);
    bone_idx_t   ids [12];
    parent_idx_t par;
    int          sent;
    int          passes;
    int          n;
    int          pick;
    sent   = 0;
    passes = 0;
    while (sent < items) begin
      n       = $urandom_range(1, 12);
      idle_on = (passes % 4 != 3);
      for (int k = 0; k < n; k++) begin
        ids[k] = bone_idx_t'($urandom_range(0, 255));
        pick   = $urandom_range(0, 99);
        if (k == 0 || pick < 10) begin
          par = parent_idx_t'(-int'($urandom_range(1, 256)));
        end else if (pick < 85) begin
          par = parent_idx_t'({1'b0, ids[$urandom_range(0, k - 1)]});
        end else begin
          par = parent_idx_t'($urandom_range(0, 255));
        end
        for (int c = 0; c < 4; c++) begin
          send_col(ids[k], par, col_idx_t'(c), rand_col(1'b0), rand_col(1'b0));
          sent++;
        end
      end
      passes++;
    end
    idle_on = 1'b1;
  endtask

  // Hold the receiver off while a chain of bones is offered back to back, so
  // the block fills and stalls its input.
  task automatic test_back_pressure();
    parent_idx_t par;
    idle_on  = 1'b0;
    hold_req = 1'b1;
    par      = -9'sd1;
    for (int k = 0; k < 10; k++) begin
      for (int c = 0; c < 4; c++) begin
        send_col(bone_idx_t'(20 + k), par, col_idx_t'(c), rand_col(1'b0), rand_col(1'b0));
      end
      par = parent_idx_t'(20 + k);
    end
    idle_on = 1'b1;
  endtask

  // Noise: any bone, any 9-bit parent, any column, often raw 32-bit values.
  task automatic test_noise(int items);
    bit wide;
    repeat (items) begin
      wide = ($urandom_range(0, 99) < 50);
      send_col(bone_idx_t'($urandom_range(0, 255)), parent_idx_t'($urandom_range(0, 511)),
               col_idx_t'($urandom_range(0, 3)), rand_col(wide), rand_col(wide));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when asked for
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left  = 0;
    skins.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        skins.ready <= 1'b0;
        stall_left--;
      end else begin
        skins.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted column against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    skin_col_t due;
    if (!rst && skins.valid === 1'b1 && skins.ready === 1'b1) begin
      if (skin_cols_due.size() == 0) begin
        $error("skin column for bone %0d with none expected", skins.out_bone);
        mismatches++;
      end else begin
        due = skin_cols_due.pop_front();
        check_field("out_bone",    32'(due.bone),    32'(skins.out_bone));
        check_field("out_column",  32'(due.col),     32'(skins.out_column));
        check_field("skin_e0",     due.skin[0],      skins.skin_e0);
        check_field("skin_e1",     due.skin[1],      skins.skin_e1);
        check_field("skin_e2",     due.skin[2],      skins.skin_e2);
        check_field("skin_e3",     due.skin[3],      skins.skin_e3);
        check_field("last_column", 32'(due.last),    32'(skins.last_column));
        check_field("overflow",    32'(due.ovf),     32'(skins.overflow));
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    bones.valid        = 1'b0;
    bones.bone_index   = '0;
    bones.parent_index = '0;
    bones.column       = '0;
    bones.local_e0     = '0;
    bones.local_e1     = '0;
    bones.local_e2     = '0;
    bones.local_e3     = '0;
    bones.offset_e0    = '0;
    bones.offset_e1    = '0;
    bones.offset_e2    = '0;
    bones.offset_e3    = '0;

    // Identity pose for every bone, as the block's clearing pass leaves it.
    for (int b = 0; b < MAX_BONES; b++) begin
      for (int i = 0; i < 16; i++) begin
        pose_store[b][i] = (i % 5 == 0) ? ONE : '0;
      end
    end
    for (int i = 0; i < 16; i++) begin
      offset_cols[i] = '0;
    end
    sat_seen = 1'b0;

    // Hold reset, then release it at a falling edge. The clearing
    // pass that follows shows up only as ready held low.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_unvisited_parent();
    test_root_extremes();
    test_saturating_child();
    test_own_parent();
    test_out_of_order();
    test_random_skeletons(280);
    test_back_pressure();
    test_noise(110);

    @(negedge clk);
    bones.valid <= 1'b0;

    // Wait for every predicted column, then give the block time to show
    // anything it should not send.
    while (skin_cols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
